### hdl/rtct_pkg.sv
// Package for the region thread-count tuner: shared types, register codes and defaults.
// Depends on nothing; used by region_thread_count_tuner_unit.
package rtct_pkg;

    localparam int unsigned DEPTH_DEFAULT = 32;
    localparam logic [8:0]  NC_RESET      = 9'd8;
    localparam logic [8:0]  ST_RESET      = 9'd2;
    localparam logic        MODE_RESET    = 1'b0;

    // Register codes (word index on the config port).
    localparam logic [1:0] REG_NUM_CORES     = 2'd0;
    localparam logic [1:0] REG_START_THREADS = 2'd1;
    localparam logic [1:0] REG_METRIC_MODE   = 2'd2;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_REPEAT = 3'd1,
        PH_S0     = 3'd2,
        PH_S1     = 3'd3,
        PH_S2     = 3'd4,
        PH_S3     = 3'd5,
        PH_END    = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        mode;
        logic [8:0]  trial;
        logic [8:0]  prior;
        logic [8:0]  step;
        logic [8:0]  best;
        logic [63:0] score;
    } t_entry;

    // Saturate an 11-bit two's complement value to 0..511.
    function automatic logic [8:0] sat9(input logic [10:0] v);
        logic [8:0] r;
        if (v[10]) begin
            r = 9'd0;
        end else if (v[9]) begin
            r = 9'd511;
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

endpackage

### hdl/rtct_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rtct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/region_thread_count_tuner_unit.sv
// Top level of the region thread-count tuner: key search, search-record update, config port.
// Depends on rtct_pkg and rtct_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------------
//  item in   | start & !busy        | i_region_key, i_elapsed_time, i_energy_used
//  result    | o_done (one cycle)   | o_thread_count, o_region_index, o_table_full
//  config    | psel&penable&pwrite  | paddr, pwdata (prdata on reads), pready tied high
//
// For each item the key search walks the key RAM one entry per cycle, then the record
// RAM is read for the current and previous region, the previous record is updated and
// written back. busy is high from the transfer until the result strobe. The receiver
// cannot stall; o_done is high for exactly one cycle and the result outputs hold their
// value until the next item's output state. Reset clears the entry count and the
// previous-region flag; record RAM entries are initialized as keys are appended, so
// there is no clearing pass.
module region_thread_count_tuner_unit #(
    parameter int unsigned TABLE_DEPTH = rtct_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] i_region_key,
    input  logic [31:0] i_elapsed_time,
    input  logic [31:0] i_energy_used,
    output logic        o_done,
    output logic [8:0]  o_thread_count,
    output logic [4:0]  o_region_index,
    output logic        o_table_full,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned EW = $bits(rtct_pkg::t_entry);

    typedef enum logic [2:0] {
        S_IDLE, S_SRCH, S_RDI, S_RDP, S_ADV, S_OUT
    } t_state;

    t_state r_state;

    // config registers
    logic [8:0] r_nc, r_st;
    logic       r_mode;

    // item registers
    logic [47:0] r_key;
    logic [31:0] r_t;
    logic [63:0] r_prod;

    // search
    logic [IW:0]   r_addr, r_count;
    logic [IW-1:0] r_ci, r_idx, r_last;
    logic          r_cv, r_full, r_last_v, r_busy;

    rtct_pkg::t_entry r_irec, r_cur;

    // outputs
    logic       r_done, r_ofull;
    logic [8:0] r_othr;
    logic [4:0] r_oidx;

    // RAM ports
    logic          k_we, e_we;
    logic [IW-1:0] k_raddr, e_waddr, e_raddr;
    logic [47:0]   k_rdata;
    rtct_pkg::t_entry e_wdata, e_rdata;
    logic [EW-1:0] e_rdata_raw;

    // ---------------------------------------------------------------- config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            rtct_pkg::REG_NUM_CORES:     prdata = {23'd0, r_nc};
            rtct_pkg::REG_START_THREADS: prdata = {23'd0, r_st};
            rtct_pkg::REG_METRIC_MODE:   prdata = {31'd0, r_mode};
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- key search
    logic hit, last_cmp, can_add;
    assign hit      = r_cv && (k_rdata == r_key);
    assign last_cmp = (r_addr == r_count);
    assign can_add  = (r_count < (IW+1)'(TABLE_DEPTH));
    assign k_raddr  = r_addr[IW-1:0];
    assign k_we     = (r_state == S_SRCH) && !hit && last_cmp && can_add;

    rtct_pkg::t_entry init_rec;
    always_comb begin
        init_rec       = '0;
        init_rec.phase = rtct_pkg::PH_START;
        init_rec.mode  = r_mode;
        init_rec.trial = r_nc;
    end

    rtct_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_keys (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    rtct_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_recs (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata_raw)
    );
    assign e_rdata = rtct_pkg::t_entry'(e_rdata_raw);

    // ---------------------------------------------------------------- advance
    // Updates the previous region's record with the score of its last run.
    rtct_pkg::t_entry p_new;
    logic             do_adv;
    logic [63:0]      score;
    logic [8:0]       nstep;

    assign do_adv = r_last_v && (e_rdata.phase != rtct_pkg::PH_END)
                    && (r_irec.phase != rtct_pkg::PH_START);

    always_comb begin
        p_new = e_rdata;
        nstep = '0;
        if (e_rdata.mode) begin
            score = r_prod;
            if (r_prod == 64'd0) begin
                p_new.phase = rtct_pkg::PH_REPEAT;
                p_new.mode  = 1'b0;
            end
        end else begin
            score = {32'd0, r_t};
        end
        case (p_new.phase)
            rtct_pkg::PH_REPEAT: begin
                p_new.phase = rtct_pkg::PH_S0;
                p_new.trial = r_st;
                p_new.prior = r_st;
            end
            rtct_pkg::PH_S0: begin
                p_new.score = score;
                p_new.best  = e_rdata.trial;
                p_new.trial = rtct_pkg::sat9({1'b0, e_rdata.trial, 1'b0});
                p_new.phase = rtct_pkg::PH_S1;
            end
            rtct_pkg::PH_S1: begin
                nstep = {1'b0, e_rdata.prior[8:1]};
                if (score < e_rdata.score) begin
                    p_new.score = score;
                    p_new.best  = e_rdata.trial;
                    if ({1'b0, e_rdata.trial, 1'b0} <= {2'b0, r_nc}) begin
                        p_new.prior = e_rdata.trial;
                        p_new.trial = rtct_pkg::sat9({1'b0, e_rdata.trial, 1'b0});
                        p_new.phase = rtct_pkg::PH_S1;
                    end else begin
                        p_new.step  = nstep;
                        p_new.trial = rtct_pkg::sat9({2'b0, e_rdata.trial}
                                                     - {2'b0, nstep});
                        p_new.phase = (nstep == 9'd1) ? rtct_pkg::PH_S3
                                                      : rtct_pkg::PH_S2;
                    end
                end else begin
                    p_new.step = nstep;
                    if (e_rdata.best == {1'b0, r_nc[8:1]}) begin
                        p_new.trial = rtct_pkg::sat9({2'b0, e_rdata.trial}
                                                     - {2'b0, nstep});
                    end else begin
                        p_new.trial = rtct_pkg::sat9({2'b0, e_rdata.trial}
                                                     + {2'b0, nstep});
                    end
                    p_new.phase = (nstep == 9'd1) ? rtct_pkg::PH_S3
                                                  : rtct_pkg::PH_S2;
                end
            end
            rtct_pkg::PH_S2: begin
                if (!(e_rdata.score < score)) begin
                    p_new.best  = e_rdata.trial;
                    p_new.score = score;
                end
                nstep       = {1'b0, e_rdata.step[8:1]};
                p_new.step  = nstep;
                p_new.trial = rtct_pkg::sat9({2'b0, e_rdata.trial} + {2'b0, nstep});
                p_new.phase = (nstep == 9'd1) ? rtct_pkg::PH_S3 : rtct_pkg::PH_S2;
            end
            rtct_pkg::PH_S3: begin
                if (score < e_rdata.score) begin
                    p_new.best = e_rdata.trial;
                end
                p_new.phase = rtct_pkg::PH_END;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- output select
    logic [8:0]       thr, hi;
    logic             cur_rep;
    rtct_pkg::t_entry cur_w;

    always_comb begin
        cur_w   = r_cur;
        cur_rep = 1'b0;
        if (!r_last_v || r_cur.phase == rtct_pkg::PH_START) begin
            cur_rep     = 1'b1;
            cur_w.phase = rtct_pkg::PH_REPEAT;
            thr         = r_nc;
        end else if (r_cur.phase == rtct_pkg::PH_END) begin
            thr = r_cur.best;
        end else begin
            thr = r_cur.trial;
        end
        hi = (r_nc == 9'd0) ? 9'd1 : r_nc;
    end

    // record RAM port mux
    always_comb begin
        e_we    = 1'b0;
        e_waddr = r_idx;
        e_wdata = cur_w;
        e_raddr = r_idx;
        unique case (r_state)
            S_SRCH: begin
                e_we    = k_we;
                e_waddr = r_count[IW-1:0];
                e_wdata = init_rec;
            end
            S_RDP: e_raddr = r_last;
            S_ADV: begin
                e_we    = do_adv;
                e_waddr = r_last;
                e_wdata = p_new;
            end
            S_OUT: e_we = cur_rep;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nc     <= rtct_pkg::NC_RESET;
            r_st     <= rtct_pkg::ST_RESET;
            r_mode   <= rtct_pkg::MODE_RESET;
            r_count  <= '0;
            r_last   <= '0;
            r_last_v <= 1'b0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_cv     <= 1'b0;
        end else begin
            // result strobe: registered, high in the cycle after the output state
            r_done <= (r_state == S_OUT);
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    rtct_pkg::REG_NUM_CORES:     r_nc   <= pwdata[8:0];
                    rtct_pkg::REG_START_THREADS: r_st   <= pwdata[8:0];
                    rtct_pkg::REG_METRIC_MODE:   r_mode <= pwdata[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key   <= i_region_key;
                        r_t     <= i_elapsed_time;
                        r_prod  <= i_elapsed_time * i_energy_used;
                        r_addr  <= '0;
                        r_cv    <= 1'b0;
                        r_busy  <= 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (hit) begin
                        r_idx   <= r_ci;
                        r_full  <= 1'b0;
                        r_state <= S_RDI;
                    end else if (last_cmp) begin
                        if (can_add) begin
                            r_idx   <= r_count[IW-1:0];
                            r_full  <= 1'b0;
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_idx  <= IW'(TABLE_DEPTH - 1);
                            r_full <= 1'b1;
                        end
                        r_state <= S_RDI;
                    end else begin
                        r_ci   <= r_addr[IW-1:0];
                        r_cv   <= 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_RDI: r_state <= S_RDP;
                S_RDP: begin
                    r_irec  <= e_rdata;
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    r_cur   <= (do_adv && r_last == r_idx) ? p_new : r_irec;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_othr   <= (thr < 9'd1) ? 9'd1 : ((thr > hi) ? hi : thr);
                    r_oidx   <= 5'(r_idx);
                    r_ofull  <= r_full;
                    r_last   <= r_idx;
                    r_last_v <= 1'b1;
                    r_busy   <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = r_busy;
    assign o_done         = r_done;
    assign o_thread_count = r_othr;
    assign o_region_index = r_oidx;
    assign o_table_full   = r_ofull;
endmodule
